// ===== sv/matrix4_inverse_core_assert.svh =====
// Assertion macros for the 4x4 matrix inverse core.
// Used by the top level only; expects clk and rst in scope.
`ifndef MATRIX4_INVERSE_CORE_ASSERT_SVH
`define MATRIX4_INVERSE_CORE_ASSERT_SVH

// Same-cycle implication, switched off during reset.
`define M4INV_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off during reset.
`define M4INV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/m4inv_pkg.sv =====
// Shared types, constants and helper functions of the 4x4 matrix inverse core.
// No dependencies; used by every module of the block.
package m4inv_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int ELEM_W         = 32;
  // 3x3 minors of 32-bit elements stay below 2^96; the determinant below 2^129.
  localparam int COF_W          = 100;
  localparam int DET_W          = 132;
  localparam int N_LANES        = 4;
  localparam int LAST_TERM      = 5;
  localparam int LAST_ROW       = 3;

  typedef enum logic [3:0] {
    L_IDLE, L_COF, L_DETT, L_WAIT, L_DSET, L_DCHK, L_DIV, L_DEND, L_DONE
  } lane_state_t;

  typedef enum logic [1:0] {M_IDLE, M_SUM, M_FIN, M_GO} merge_state_t;

  typedef enum logic [1:0] {T_LOAD, T_BUSY, T_OUT} top_state_t;

  typedef struct packed {
    logic term_valid;
    logic done;
  } lane_stat_t;

  typedef struct packed {
    logic             go;
    logic             singular;
    logic             neg;
    logic [DET_W-1:0] mag;
  } det_ctl_t;

  // Index i of a minor mapped back to the full matrix, skipping excl.
  function automatic logic [1:0] minor_idx(input logic [1:0] i, input logic [1:0] excl);
    minor_idx = (i < excl) ? i : i + 2'd1;
  endfunction

  // Minor column used by minor row i in term t of the 3x3 expansion.
  function automatic logic [1:0] term_col(input logic [2:0] t, input logic [1:0] i);
    logic [5:0] p;
    case (t)
      3'd0: p = {2'd2, 2'd1, 2'd0};
      3'd1: p = {2'd1, 2'd2, 2'd0};
      3'd2: p = {2'd2, 2'd0, 2'd1};
      3'd3: p = {2'd0, 2'd2, 2'd1};
      3'd4: p = {2'd1, 2'd0, 2'd2};
      3'd5: p = {2'd0, 2'd1, 2'd2};
      default: p = {2'd2, 2'd1, 2'd0};
    endcase
    term_col = p[2*i +: 2];
  endfunction

  // Odd permutations enter the 3x3 determinant negated.
  function automatic logic term_neg(input logic [2:0] t);
    term_neg = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
  endfunction

endpackage

// ===== sv/matrix4_inverse_core.sv =====
// Block usage:
// The input channel (in_valid, in_stall, col0..col3) carries one matrix row
// per word, row 0 first, four signed fixed-point elements. Rows 0 to 2 are
// only stored. The fourth row starts the computation: four lanes, one per
// column, form the cofactors on a shared 33x32 multiplier each (24 triple
// products), the merging stage sums the determinant, and each lane then
// runs four restoring divisions of one quotient bit per cycle. Four result
// words follow, one inverse row each, with the determinant, the singular
// flag and last_row on the fourth. While results are being delivered the
// first three rows of the next matrix may already be taken; its fourth row
// is stalled until the last result word has gone. A stalled result word
// holds all its fields. Reset clears the row count and all sequencers;
// stored elements need no reset.
`include "matrix4_inverse_core_assert.svh"

module matrix4_inverse_core #(
  parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = m4inv_pkg::WORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] col0,
  input  logic signed [31:0] col1,
  input  logic signed [31:0] col2,
  input  logic signed [31:0] col3,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row,
  output logic signed [31:0] inv0,
  output logic signed [31:0] inv1,
  output logic signed [31:0] inv2,
  output logic signed [31:0] inv3,
  output logic signed [31:0] determinant,
  output logic               singular,
  output logic               last_row
);

  localparam int EW = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;

  m4inv_pkg::top_state_t state, state_next;

  logic [31:0]                        store [16];
  logic [15:0][31:0]                  elem;
  logic [1:0]                         row_count;
  logic [1:0]                         orow;
  logic                               start, in_acc, out_acc, all_done;
  m4inv_pkg::lane_stat_t              lane_stat [m4inv_pkg::N_LANES];
  logic signed [m4inv_pkg::DET_W-1:0] lane_term [m4inv_pkg::N_LANES];
  logic [3:0][31:0]                   lane_inv  [m4inv_pkg::N_LANES];
  m4inv_pkg::det_ctl_t                ctl;
  logic [31:0]                        det_out;

  // Elements narrower than 32 bits are sign-extended from their top bit.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      elem[i] = 32'($signed(store[i] << (32 - EW)) >>> (32 - EW));
    end
  end

  assign all_done = lane_stat[0].done & lane_stat[1].done &
                    lane_stat[2].done & lane_stat[3].done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m4inv_pkg::T_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state == m4inv_pkg::T_BUSY) ||
                 (state == m4inv_pkg::T_OUT && row_count == 2'(m4inv_pkg::LAST_ROW));
    out_valid  = (state == m4inv_pkg::T_OUT);
    in_acc     = in_valid && !in_stall;
    out_acc    = out_valid && !out_stall;
    start      = in_acc && row_count == 2'(m4inv_pkg::LAST_ROW);
    case (state)
      m4inv_pkg::T_LOAD: if (start) state_next = m4inv_pkg::T_BUSY;
      m4inv_pkg::T_BUSY: if (all_done) state_next = m4inv_pkg::T_OUT;
      m4inv_pkg::T_OUT: begin
        if (out_acc && orow == 2'(m4inv_pkg::LAST_ROW)) state_next = m4inv_pkg::T_LOAD;
      end
      default: state_next = m4inv_pkg::T_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      orow      <= '0;
    end else begin
      if (in_acc) row_count <= row_count + 2'd1;
      if (out_acc) orow <= orow + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      store[{row_count, 2'd0}] <= col0;
      store[{row_count, 2'd1}] <= col1;
      store[{row_count, 2'd2}] <= col2;
      store[{row_count, 2'd3}] <= col3;
    end
  end

  for (genvar g = 0; g < m4inv_pkg::N_LANES; g++) begin : g_lane
    m4inv_lane #(
      .FRAC_BITS  (FRAC_BITS),
      .WORD_WIDTH (WORD_WIDTH)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .lane_col (2'(g)),
      .start    (start),
      .elem     (elem),
      .ctl      (ctl),
      .stat     (lane_stat[g]),
      .term     (lane_term[g]),
      .inv      (lane_inv[g])
    );
  end

  m4inv_merge #(
    .FRAC_BITS  (FRAC_BITS),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .stat    (lane_stat),
    .term    (lane_term),
    .ctl     (ctl),
    .det_out (det_out)
  );

  // Lane n holds inverse row n; a singular matrix gives zero elements.
  always_comb begin
    out_row     = orow;
    last_row    = (orow == 2'(m4inv_pkg::LAST_ROW));
    singular    = ctl.singular;
    determinant = det_out;
    inv0        = ctl.singular ? 32'sd0 : $signed(lane_inv[orow][0]);
    inv1        = ctl.singular ? 32'sd0 : $signed(lane_inv[orow][1]);
    inv2        = ctl.singular ? 32'sd0 : $signed(lane_inv[orow][2]);
    inv3        = ctl.singular ? 32'sd0 : $signed(lane_inv[orow][3]);
  end

  `M4INV_ASSERT_IMPL(a_out_needs_done, out_valid, all_done, "result word before lanes finished")
  `M4INV_ASSERT_NEXT(a_start_quiet, start, !out_valid, "result word right after a fourth row")
  `M4INV_ASSERT_NEXT(a_last_closes, out_acc && last_row, !out_valid, "extra result word after last row")

endmodule

// ===== sv/m4inv_lane.sv =====
// One lane: cofactors of one matrix column, its determinant term and the
// divisions giving one inverse row. Depends on m4inv_pkg.
module m4inv_lane #(
  parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = m4inv_pkg::WORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [1:0]                            lane_col,
  input  logic                                  start,
  input  logic [15:0][m4inv_pkg::ELEM_W-1:0]    elem,
  input  m4inv_pkg::det_ctl_t                   ctl,
  output m4inv_pkg::lane_stat_t                 stat,
  output logic signed [m4inv_pkg::DET_W-1:0]    term,
  output logic [3:0][31:0]                      inv
);

  localparam int COF_W = m4inv_pkg::COF_W;
  localparam int DET_W = m4inv_pkg::DET_W;
  localparam int NW    = ((COF_W + 2*FRAC_BITS) > DET_W ? (COF_W + 2*FRAC_BITS) : DET_W) + 2;
  localparam int CW    = $clog2(WORD_WIDTH);

  m4inv_pkg::lane_state_t state, state_next;

  logic [1:0]              r;
  logic [2:0]              t;
  logic [1:0]              sub;
  logic [2:0]              dk;
  logic [CW-1:0]           cnt;

  logic signed [32:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic signed [64:0]      prod;
  logic signed [31:0]      p_hi;
  logic signed [COF_W-1:0] acc, acc_sum, addend;
  logic signed [COF_W-1:0] cof [4];
  logic signed [DET_W-1:0] dacc, dadd;

  logic [NW-1:0]           num, dd, rem, trial;
  logic [WORD_WIDTH-1:0]   nlow, qb;
  logic                    neg, big, ge;
  logic [COF_W-1:0]        cabs;
  logic [63:0]             lim, q64, mag, res;

  logic [1:0]              rr0, rr1, rr2, cc0, cc1, cc2;
  logic signed [31:0]      ea, eb, ec, e0c;

  // Element selection for the current term of the current minor.
  always_comb begin
    rr0 = m4inv_pkg::minor_idx(2'd0, r);
    rr1 = m4inv_pkg::minor_idx(2'd1, r);
    rr2 = m4inv_pkg::minor_idx(2'd2, r);
    cc0 = m4inv_pkg::minor_idx(m4inv_pkg::term_col(t, 2'd0), lane_col);
    cc1 = m4inv_pkg::minor_idx(m4inv_pkg::term_col(t, 2'd1), lane_col);
    cc2 = m4inv_pkg::minor_idx(m4inv_pkg::term_col(t, 2'd2), lane_col);
    ea  = $signed(elem[{rr0, cc0}]);
    eb  = $signed(elem[{rr1, cc1}]);
    ec  = $signed(elem[{rr2, cc2}]);
    e0c = $signed(elem[{2'd0, lane_col}]);
  end

  // A triple product a*b*c takes three multiplies: a*b, then its low and
  // high halves each times c.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == m4inv_pkg::L_COF) begin
      case (sub)
        2'd0: begin
          mul_a = 33'(ea);
          mul_b = eb;
        end
        2'd1: begin
          mul_a = {1'b0, prod[31:0]};
          mul_b = ec;
        end
        2'd2: begin
          mul_a = 33'(p_hi);
          mul_b = ec;
        end
        default: ;
      endcase
    end else if (state == m4inv_pkg::L_DETT) begin
      mul_b = e0c;
      case (dk)
        3'd0: mul_a = {1'b0, cof[0][31:0]};
        3'd1: mul_a = {1'b0, cof[0][63:32]};
        3'd2: mul_a = {1'b0, cof[0][95:64]};
        3'd3: mul_a = 33'($signed(cof[0][COF_W-1:96]));
        default: mul_a = '0;
      endcase
    end
  end

  always_comb begin
    addend  = (sub == 2'd3) ? (COF_W'(prod) <<< 32) : COF_W'(prod);
    acc_sum = m4inv_pkg::term_neg(t) ? acc - addend : acc + addend;
    case (dk)
      3'd1:    dadd = DET_W'(prod);
      3'd2:    dadd = DET_W'(prod) <<< 32;
      3'd3:    dadd = DET_W'(prod) <<< 64;
      3'd4:    dadd = DET_W'(prod) <<< 96;
      default: dadd = '0;
    endcase
  end

  always_comb begin
    cabs  = cof[r][COF_W-1] ? COF_W'(-cof[r]) : COF_W'(cof[r]);
    trial = {rem[NW-2:0], nlow[WORD_WIDTH-1]};
    ge    = trial >= dd;
    lim   = (64'd1 << (WORD_WIDTH - 1)) - (neg ? 64'd0 : 64'd1);
    q64   = 64'(qb);
    mag   = (big || (q64 > lim)) ? lim : q64;
    res   = neg ? 64'd0 - mag : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m4inv_pkg::L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    stat       = '0;
    case (state)
      m4inv_pkg::L_IDLE: begin
        if (start) state_next = m4inv_pkg::L_COF;
      end
      m4inv_pkg::L_COF: begin
        if (sub == 2'd3 && t == 3'(m4inv_pkg::LAST_TERM) && r == 2'(m4inv_pkg::LAST_ROW)) begin
          state_next = m4inv_pkg::L_DETT;
        end
      end
      m4inv_pkg::L_DETT: begin
        if (dk == 3'd4) state_next = m4inv_pkg::L_WAIT;
      end
      m4inv_pkg::L_WAIT: begin
        stat.term_valid = 1'b1;
        if (ctl.go) state_next = m4inv_pkg::L_DSET;
      end
      m4inv_pkg::L_DSET: state_next = m4inv_pkg::L_DCHK;
      m4inv_pkg::L_DCHK: state_next = m4inv_pkg::L_DIV;
      m4inv_pkg::L_DIV: begin
        if (cnt == CW'(WORD_WIDTH - 1)) state_next = m4inv_pkg::L_DEND;
      end
      m4inv_pkg::L_DEND: begin
        state_next = (r == 2'(m4inv_pkg::LAST_ROW)) ? m4inv_pkg::L_DONE : m4inv_pkg::L_DSET;
      end
      m4inv_pkg::L_DONE: begin
        stat.done = 1'b1;
        if (start) state_next = m4inv_pkg::L_COF;
      end
      default: state_next = m4inv_pkg::L_IDLE;
    endcase
  end

  // Sequencing counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      r   <= '0;
      t   <= '0;
      sub <= '0;
      dk  <= '0;
      cnt <= '0;
    end else begin
      case (state)
        m4inv_pkg::L_IDLE, m4inv_pkg::L_DONE: begin
          r   <= '0;
          t   <= '0;
          sub <= '0;
        end
        m4inv_pkg::L_COF: begin
          sub <= sub + 2'd1;
          dk  <= '0;
          if (sub == 2'd3) begin
            if (t == 3'(m4inv_pkg::LAST_TERM)) begin
              t <= '0;
              r <= r + 2'd1;
            end else begin
              t <= t + 3'd1;
            end
          end
        end
        m4inv_pkg::L_DETT: dk  <= dk + 3'd1;
        m4inv_pkg::L_DCHK: cnt <= '0;
        m4inv_pkg::L_DIV:  cnt <= cnt + CW'(1);
        m4inv_pkg::L_DEND: r   <= r + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      m4inv_pkg::L_IDLE, m4inv_pkg::L_DONE: acc <= '0;
      m4inv_pkg::L_COF: begin
        dacc <= '0;
        case (sub)
          2'd1: p_hi <= prod[63:32];
          2'd2: acc  <= acc_sum;
          2'd3: begin
            if (t == 3'(m4inv_pkg::LAST_TERM)) begin
              cof[r] <= (r[0] ^ lane_col[0]) ? -acc_sum : acc_sum;
              acc    <= '0;
            end else begin
              acc <= acc_sum;
            end
          end
          default: ;
        endcase
      end
      m4inv_pkg::L_DETT: dacc <= dacc + dadd;
      m4inv_pkg::L_DSET: begin
        num <= (NW'(cabs) << (2*FRAC_BITS + 1)) + NW'(ctl.mag);
        dd  <= NW'(ctl.mag) << 1;
        neg <= cof[r][COF_W-1] ^ ctl.neg;
      end
      m4inv_pkg::L_DCHK: begin
        rem  <= num >> WORD_WIDTH;
        big  <= (num >> WORD_WIDTH) >= dd;
        nlow <= num[WORD_WIDTH-1:0];
        qb   <= '0;
      end
      m4inv_pkg::L_DIV: begin
        rem  <= ge ? trial - dd : trial;
        qb   <= {qb[WORD_WIDTH-2:0], ge};
        nlow <= nlow << 1;
      end
      m4inv_pkg::L_DEND: inv[r] <= res[31:0];
      default: ;
    endcase
  end

  assign term = dacc;

endmodule

// ===== sv/m4inv_merge.sv =====
// Merging stage: sums the lane determinant terms, rounds the determinant
// word and hands magnitude and sign back to the lanes. Depends on m4inv_pkg.
module m4inv_merge #(
  parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = m4inv_pkg::WORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  m4inv_pkg::lane_stat_t              stat [m4inv_pkg::N_LANES],
  input  logic signed [m4inv_pkg::DET_W-1:0] term [m4inv_pkg::N_LANES],
  output m4inv_pkg::det_ctl_t                ctl,
  output logic [31:0]                        det_out
);

  localparam int DET_W = m4inv_pkg::DET_W;

  m4inv_pkg::merge_state_t state, state_next;

  logic signed [DET_W-1:0] s01, s23, det;
  logic [DET_W-1:0]        mag, det_abs, qround, lim, mag_s;
  logic                    neg, sing, all_valid;
  logic [63:0]             res;

  assign all_valid = stat[0].term_valid & stat[1].term_valid &
                     stat[2].term_valid & stat[3].term_valid;

  // Determinant word: round half away from zero, then clamp.
  always_comb begin
    det_abs = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
    qround  = (det_abs + (DET_W'(1) << (3*FRAC_BITS - 1))) >> (3*FRAC_BITS);
    lim     = (DET_W'(1) << (WORD_WIDTH - 1)) - (det[DET_W-1] ? DET_W'(0) : DET_W'(1));
    mag_s   = (qround > lim) ? lim : qround;
    res     = det[DET_W-1] ? 64'd0 - 64'(mag_s) : 64'(mag_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m4inv_pkg::M_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      m4inv_pkg::M_IDLE: if (all_valid) state_next = m4inv_pkg::M_SUM;
      m4inv_pkg::M_SUM:  state_next = m4inv_pkg::M_FIN;
      m4inv_pkg::M_FIN:  state_next = m4inv_pkg::M_GO;
      m4inv_pkg::M_GO:   state_next = m4inv_pkg::M_IDLE;
      default:           state_next = m4inv_pkg::M_IDLE;
    endcase
    ctl.go       = (state == m4inv_pkg::M_GO);
    ctl.singular = sing;
    ctl.neg      = neg;
    ctl.mag      = mag;
  end

  always_ff @(posedge clk) begin
    case (state)
      m4inv_pkg::M_IDLE: begin
        s01 <= term[0] + term[1];
        s23 <= term[2] + term[3];
      end
      m4inv_pkg::M_SUM: det <= s01 + s23;
      m4inv_pkg::M_FIN: begin
        mag     <= det_abs;
        neg     <= det[DET_W-1];
        sing    <= (det == '0);
        det_out <= res[31:0];
      end
      default: ;
    endcase
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for matrix4_inverse_core: rows go in, inverse rows are checked.
// Depends on the core RTL; expected values: a wide-integer model or typed cases.
`timescale 1ns / 100ps

module tb_top;

  typedef logic signed [255:0] wide_t;
  typedef logic [15:0][31:0] mat_t;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] inv [4];
    logic [31:0] det;
    logic        sing;
    logic        last;
  } inv_row_t;

  typedef struct {
    mat_t        m;
    bit          typed;
    logic [31:0] t_det;
    logic        t_sing;
    logic [31:0] t_diag;
  } mat_case_t;

  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam int N_RAND = 36;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] col0 = '0, col1 = '0, col2 = '0, col3 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_row;
  logic signed [31:0] inv0, inv1, inv2, inv3, determinant;
  logic singular, last_row;

  inv_row_t  pending_rows[$];
  mat_t      rx_mat;
  int        rx_count = 0;
  int        fail_count = 0;
  bit        calm = 1'b0;
  bit        done_sending = 1'b0;
  mat_case_t dir_tab [6];

  always #10 clk = ~clk;

  matrix4_inverse_core i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .col0(col0), .col1(col1), .col2(col2), .col3(col3),
    .out_valid(out_valid), .out_stall(out_stall), .out_row(out_row),
    .inv0(inv0), .inv1(inv1), .inv2(inv2), .inv3(inv3),
    .determinant(determinant), .singular(singular), .last_row(last_row)
  );

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    fail_count++;
  endtask

  // Rounds n/d to nearest, ties away from zero, and clamps to 32 bits.
  function automatic logic [31:0] round_div_sat(input wide_t n, input wide_t d);
    logic [255:0] an, ad, q, lim;
    logic neg;
    neg = (n < 0) != (d < 0);
    an  = (n < 0) ? -n : n;
    ad  = (d < 0) ? -d : d;
    q   = ((an << 1) + ad) / (ad << 1);
    lim = neg ? 256'h8000_0000 : 256'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic wide_t cofactor_of(input mat_t m, input int r, input int c);
    wide_t a [3][3];
    wide_t v;
    logic signed [31:0] e;
    int ri, ci;
    ri = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != r) begin
        ci = 0;
        for (int j = 0; j < 4; j++) begin
          if (j != c) begin
            e = m[i*4+j];
            a[ri][ci] = e;
            ci++;
          end
        end
        ri++;
      end
    end
    v = a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
      - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
      + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
    return ((r + c) % 2) ? -v : v;
  endfunction

  task automatic predict_inverse(input mat_t m);
    wide_t cof [4][4];
    wide_t dexact;
    logic signed [31:0] e;
    inv_row_t res;
    dexact = '0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) cof[i][j] = cofactor_of(m, i, j);
    for (int j = 0; j < 4; j++) begin
      e = m[j];
      dexact += wide_t'(e) * cof[0][j];
    end
    for (int i = 0; i < 4; i++) begin
      res.row  = i[1:0];
      res.sing = (dexact == 0);
      res.det  = res.sing ? '0 : round_div_sat(dexact, wide_t'(1) <<< 48);
      res.last = (i == 3);
      for (int j = 0; j < 4; j++)
        res.inv[j] = res.sing ? '0 : round_div_sat(cof[j][i] <<< 32, dexact);
      pending_rows.push_back(res);
    end
  endtask

  task automatic push_typed(input mat_case_t t);
    inv_row_t res;
    for (int i = 0; i < 4; i++) begin
      res.row  = i[1:0];
      res.det  = t.t_det;
      res.sing = t.t_sing;
      res.last = (i == 3);
      for (int j = 0; j < 4; j++) res.inv[j] = (i == j) ? t.t_diag : '0;
      pending_rows.push_back(res);
    end
  endtask

  // Sends one matrix; expectations are queued when the fourth word is taken.
  task automatic send_matrix(input mat_case_t t);
    for (int r = 0; r < 4; r++) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      in_valid <= 1'b1;
      col0 <= t.m[r*4];
      col1 <= t.m[r*4+1];
      col2 <= t.m[r*4+2];
      col3 <= t.m[r*4+3];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (r == 3) begin
        if (t.typed) push_typed(t);
        else predict_inverse(t.m);
      end
      @(negedge clk);
    end
  endtask

  function automatic mat_t random_matrix();
    mat_t m;
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 16; k++) begin
      case (mode)
        6:       m[k] = $urandom;
        9:       m[k] = $urandom_range(0, 510) - 255;
        8:       m[k] = (k % 5 == 0) ? $urandom_range(ONE, 8 * ONE)
                                     : $urandom_range(0, 2 * 16384) - 16384;
        default: m[k] = $urandom_range(0, 2 ** 19) - 2 ** 18;
      endcase
    end
    // Repeated row gives a singular matrix with random content.
    if (mode == 7)
      for (int j = 0; j < 4; j++) m[12+j] = m[4+j];
    return m;
  endfunction

  always @(posedge clk) begin
    inv_row_t want;
    logic [31:0] got_inv [4];
    if (!rst && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        report_mismatch("unexpected result word, out_row", 32'(out_row), '0);
      end else begin
        want = pending_rows.pop_front();
        got_inv = '{inv0, inv1, inv2, inv3};
        if (out_row != want.row) report_mismatch("out_row", out_row, want.row);
        for (int j = 0; j < 4; j++)
          if (got_inv[j] != want.inv[j])
            report_mismatch($sformatf("inv%0d row %0d", j, want.row), got_inv[j], want.inv[j]);
        if (determinant != want.det) report_mismatch("determinant", determinant, want.det);
        if (singular != want.sing) report_mismatch("singular", singular, want.sing);
        if (last_row != want.last) report_mismatch("last_row", last_row, want.last);
      end
    end
  end

  // Receiver back-pressure in random bursts, dropped once the run is calm.
  always @(negedge clk) begin
    if (calm || rst) begin
      out_stall <= 1'b0;
    end else if (!out_stall && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      rx_count  <= $urandom_range(1, 19);
    end else if (out_stall) begin
      if (rx_count <= 1) out_stall <= 1'b0;
      rx_count <= rx_count - 1;
    end
  end

  initial begin
    mat_case_t t;
    dir_tab[0] = '{m: '0, typed: 1, t_det: ONE, t_sing: 0, t_diag: ONE};
    dir_tab[1] = '{m: '0, typed: 1, t_det: '0, t_sing: 1, t_diag: '0};
    dir_tab[2] = '{m: {16{MAXV}}, typed: 1, t_det: '0, t_sing: 1, t_diag: '0};
    dir_tab[3] = '{m: '0, typed: 0, t_det: '0, t_sing: 0, t_diag: '0};
    dir_tab[4] = '{m: '0, typed: 1, t_det: 32'h0010_0000, t_sing: 0, t_diag: 32'h8000};
    dir_tab[5] = '{m: '0, typed: 0, t_det: '0, t_sing: 0, t_diag: '0};
    for (int k = 0; k < 4; k++) begin
      dir_tab[0].m[k*5] = ONE;
      dir_tab[3].m[k*5] = 32'd1;
      dir_tab[4].m[k*5] = 2 * ONE;
      dir_tab[5].m[k*5] = (k % 2) ? MINV : MAXV;
    end
    dir_tab[5].m[3]  = MINV;
    dir_tab[5].m[12] = MAXV;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_tab[n]) send_matrix(dir_tab[n]);
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND - 8) calm = 1'b1;
      t = '{m: random_matrix(), typed: 0, t_det: '0, t_sing: 0, t_diag: '0};
      send_matrix(t);
    end
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_rows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout waiting for results");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
